### hw/rtl/mspfe_pkg.sv
// Shared types, constants and CRC functions for the MSP v2 frame encoder.
package mspfe_pkg;

   // Most words one input item can cause: eight header bytes plus the CRC.
   localparam int unsigned MaxWords = 9;
   localparam int unsigned CountW   = $clog2(MaxWords + 1);

   // CRC-8 DVB-S2 polynomial and the bit that decides the feedback.
   localparam logic [7:0] CrcPoly   = 8'hD5;
   localparam logic [7:0] CrcTopBit = 8'h80;

   // Fixed header characters.
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChX      = 8'h58;
   localparam logic [7:0] ChLess   = 8'h3C;
   localparam logic [7:0] ChFlag   = 8'h30;

   typedef enum logic {
      OP_START = 1'b0,
      OP_DATA  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [7:0]  crc;
      logic [15:0] remaining;
      logic        open;
   } frame_state_type;

   typedef struct packed {
      frame_state_type                next_state;
      logic [MaxWords-1:0][7:0]       words;
      logic [CountW-1:0]              count;
      logic                           has_crc;
   } build_result_type;

   // One byte through the CRC, most significant bit first.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CrcTopBit) != 8'h00) begin
            c = (c << 1) ^ CrcPoly;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   // CRC over the flag byte, the function code and the length, low byte first.
   function automatic logic [7:0] crc8_header(input logic [15:0] fc, input logic [15:0] len);
      logic [7:0] c;
      c = crc8_step(8'h00, ChFlag);
      c = crc8_step(c, fc[7:0]);
      c = crc8_step(c, fc[15:8]);
      c = crc8_step(c, len[7:0]);
      c = crc8_step(c, len[15:8]);
      return c;
   endfunction

endpackage

### hw/rtl/mspfe_frame_build.sv
// Combinational frame builder: the words one item causes and the next frame state.
module mspfe_frame_build (
   input  mspfe_pkg::opcode_type       opcode,
   input  logic [15:0]                 function_code,
   input  logic [15:0]                 payload_length,
   input  logic [7:0]                  data_byte,
   input  mspfe_pkg::frame_state_type  cur_state,
   output mspfe_pkg::build_result_type result
);
   import mspfe_pkg::*;

   logic [7:0]  hdr_crc;
   logic [7:0]  data_crc;
   logic [15:0] rem_dec;

   assign hdr_crc  = crc8_header(function_code, payload_length);
   assign data_crc = crc8_step(cur_state.crc, data_byte);
   assign rem_dec  = cur_state.remaining - 16'd1;

   // Pick the header or payload words and update the running frame state.
   always_comb begin
      result            = '0;
      result.next_state = cur_state;
      unique case (opcode)
         OP_START: begin
            result.words[0] = ChDollar;
            result.words[1] = ChX;
            result.words[2] = ChLess;
            result.words[3] = ChFlag;
            result.words[4] = function_code[7:0];
            result.words[5] = function_code[15:8];
            result.words[6] = payload_length[7:0];
            result.words[7] = payload_length[15:8];
            result.next_state.crc = hdr_crc;
            if (payload_length == 16'd0) begin
               // Empty payload: the frame closes right after the header.
               result.words[8]             = hdr_crc;
               result.count                = CountW'(9);
               result.has_crc              = 1'b1;
               result.next_state.remaining = 16'd0;
               result.next_state.open      = 1'b0;
            end else begin
               result.count                = CountW'(8);
               result.next_state.remaining = payload_length;
               result.next_state.open      = 1'b1;
            end
         end
         OP_DATA: begin
            if (cur_state.open) begin
               result.words[0]             = data_byte;
               result.next_state.crc       = data_crc;
               result.next_state.remaining = rem_dec;
               if (rem_dec == 16'd0) begin
                  // Last payload byte: append the checksum and close the frame.
                  result.words[1]        = data_crc;
                  result.count           = CountW'(2);
                  result.has_crc         = 1'b1;
                  result.next_state.open = 1'b0;
               end else begin
                  result.count = CountW'(1);
               end
            end
         end
         default: begin
            result.count = '0;
         end
      endcase
   end

endmodule

### hw/rtl/msp_v2_frame_encoder_unit.sv
// Top level of the MSP v2 frame encoder: input handshake, frame state and output word queue.
// The first result word is shown in the cycle after its input word is accepted.
// Throughput: a start word gives 8 result words (9 with an empty payload), a data word gives 1
// (2 on the last payload byte, which brings the CRC); one result word leaves per cycle
// while rsp_tready is high. The next input word is taken in the same cycle the last queued
// result word is taken, so payload bytes stream at one per cycle while rsp_tready is high.
// Reset clears the CRC, the remaining count and the queue; no frame is open after reset.
module msp_v2_frame_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // function_code[15:0], payload_length[31:16], data_byte[39:32]
   input  logic        req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast,   // frame_end
   output logic        rsp_tuser    // run_last[0]
);
   import mspfe_pkg::*;

   frame_state_type          state_ff;
   frame_state_type          state_in;
   logic [MaxWords-1:0][7:0] words_ff;
   logic [MaxWords-1:0][7:0] words_in;
   logic [CountW-1:0]        count_ff;
   logic [CountW-1:0]        count_in;
   logic                     has_crc_ff;
   logic                     has_crc_in;
   build_result_type         build;
   logic                     accept;
   logic                     pop;
   logic                     last_word;

   // Frame builder works straight off the accepted word.
   mspfe_frame_build u_build (
      .opcode         (opcode_type'(req_tuser)),
      .function_code  (req_tdata[15:0]),
      .payload_length (req_tdata[31:16]),
      .data_byte      (req_tdata[39:32]),
      .cur_state      (state_ff),
      .result         (build)
   );

   // Handshake: a new word enters when the queue is empty or drains this cycle.
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign last_word  = (count_ff == CountW'(1));
   assign req_tready = (count_ff == '0) || (pop && last_word);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tdata = words_ff[0];
   assign rsp_tuser = last_word;
   assign rsp_tlast = last_word && has_crc_ff;

   // Next values of the frame state and the output queue.
   always_comb begin
      state_in   = state_ff;
      words_in   = words_ff;
      count_in   = count_ff;
      has_crc_in = has_crc_ff;
      if (accept) begin
         state_in   = build.next_state;
         words_in   = build.words;
         count_in   = build.count;
         has_crc_in = build.has_crc;
      end else if (pop) begin
         words_in = words_ff >> 8;
         count_in = count_ff - CountW'(1);
      end
   end

   // Control state is reset; the queued words need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         count_ff   <= '0;
         has_crc_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         has_crc_ff <= has_crc_in;
      end
      words_ff <= words_in;
   end

   // The queue never holds more words than one item can cause.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CountW'(MaxWords))
      else $error("output queue overfilled");

   // No new word may enter while more than one result word is still queued.
   assert property (@(posedge clock) disable iff (reset) (count_ff > CountW'(1)) |-> !req_tready)
      else $error("input taken while results still queued");

   // An open frame always expects at least one more payload byte.
   assert property (@(posedge clock) disable iff (reset) state_ff.open |-> state_ff.remaining != 16'd0)
      else $error("open frame with nothing remaining");

   // The checksum word is always the last word of its item.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("frame end not on last word of item");

   // Once the checksum is taken, no frame stays open unless a new start came in.
   assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_tlast && !accept) |=> !state_ff.open)
      else $error("frame still open after checksum");

endmodule
